/* sv/assert_macros.svh */
// Assertion macros for the RTL files; included by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/tspa_pkg.sv */
// Types and command codes of the tagged slot pool allocator.
`timescale 1ns / 1ps
package tspa_pkg;

    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_KILL  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [7:0]          entity_type;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
    } request_t;

    typedef struct packed {
        logic                hit;
        logic [3:0]          slot_index;
        logic signed [15:0]  found_x;
        logic signed [15:0]  found_y;
        logic [4:0]          active_count;
    } result_t;

    typedef struct packed {
        logic                active;
        logic [7:0]          slot_type;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
    } slot_entry_t;

endpackage

/* sv/tagged_slot_pool_allocator.sv */
// Top level of the tagged slot pool allocator: command sequencer around the slot memory.
//
// Usage:
//   A request (command, entity_type, pos_x, pos_y) is taken at a clock edge where start
//   is high and busy is low. Each request gives one result, shown on result for exactly
//   one cycle with done high; the receiver cannot stall it.
//   Clear finishes at once: done is high in the cycle after the request.
//   Spawn, find and kill walk the slot memory from slot 0, one read a cycle with the
//   check made in the cycle after the read. Spawn and find stop at the first hit, kill
//   walks all slots.
//   busy is low again in the cycle that shows done, so the next request may be taken
//   while the result is on the port.
//   Reset empties the pool: per-slot valid flops are cleared, so the memory needs no
//   clearing pass, and clear works the same way.
//   active_count is the number of active slots after the request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tagged_slot_pool_allocator #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tspa_pkg::request_t request,
    output logic               done,
    output tspa_pkg::result_t  result
);
    import tspa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg,   state_next;
    logic [1:0]        op_reg,      op_next;
    logic [7:0]        typ_reg,     typ_next;
    logic signed [15:0] x_reg,      x_next;
    logic signed [15:0] y_reg,      y_next;
    logic [IW:0]       rd_idx_reg,  rd_idx_next;
    logic              chk_v_reg,   chk_v_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              rd_vld_reg,  rd_vld_next;
    logic [SLOTS-1:0]  vld_reg,     vld_next;
    logic [CW-1:0]     cnt_reg,     cnt_next;
    logic              done_reg,    done_next;
    result_t           result_reg,  result_next;

    logic          accept;
    logic          rd_en;
    logic          mem_we;
    slot_entry_t   mem_wdata;
    slot_entry_t   mem_rdata;
    slot_entry_t   entry;
    logic          hit_now;
    logic          last_chk;
    logic          finish;

    tspa_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (chk_idx_reg),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg == ST_SCAN);
    assign accept = start && !busy;
    assign rd_en  = (state_reg == ST_SCAN) && (rd_idx_reg != (IW+1)'(SLOTS));

    // never-written slots read as empty
    assign entry = rd_vld_reg ? mem_rdata : '0;

    always_comb
    begin
        hit_now = 1'b0;
        if (chk_v_reg)
        begin
            if (op_reg == CMD_SPAWN)
            begin
                hit_now = !entry.active;
            end
            else
            begin
                hit_now = entry.active && (entry.slot_type == typ_reg);
            end
        end
    end

    assign last_chk = chk_v_reg && (chk_idx_reg == IW'(SLOTS - 1));
    assign mem_we   = (state_reg == ST_SCAN) && hit_now &&
                      ((op_reg == CMD_SPAWN) || (op_reg == CMD_KILL));
    assign finish   = (state_reg == ST_SCAN) &&
                      ((hit_now && (op_reg != CMD_KILL)) || last_chk);

    always_comb
    begin
        mem_wdata = entry;
        if (op_reg == CMD_SPAWN)
        begin
            mem_wdata.active    = 1'b1;
            mem_wdata.slot_type = typ_reg;
            mem_wdata.x         = x_reg;
            mem_wdata.y         = y_reg;
        end
        else
        begin
            mem_wdata.active = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        typ_next     = typ_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rd_idx_next  = rd_idx_reg;
        chk_v_next   = rd_en && !finish;
        chk_idx_next = rd_idx_reg[IW-1:0];
        rd_vld_next  = rd_en ? vld_reg[rd_idx_reg[IW-1:0]] : rd_vld_reg;
        vld_next     = vld_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + (IW+1)'(1);
        end

        if (mem_we)
        begin
            if (op_reg == CMD_SPAWN)
            begin
                vld_next[chk_idx_reg] = 1'b1;
                cnt_next              = cnt_reg + CW'(1);
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end

        if (finish)
        begin
            state_next              = ST_IDLE;
            done_next               = 1'b1;
            result_next             = '0;
            result_next.active_count = 5'(cnt_next);
            if (hit_now && (op_reg != CMD_KILL))
            begin
                result_next.hit        = 1'b1;
                result_next.slot_index = 4'(chk_idx_reg);
                result_next.found_x    = (op_reg == CMD_SPAWN) ? x_reg : entry.x;
                result_next.found_y    = (op_reg == CMD_SPAWN) ? y_reg : entry.y;
            end
        end

        if (accept)
        begin
            op_next     = request.command;
            typ_next    = request.entity_type;
            x_next      = request.pos_x;
            y_next      = request.pos_y;
            rd_idx_next = '0;
            case (request.command)
                CMD_CLEAR:
                begin
                    vld_next    = '0;
                    cnt_next    = '0;
                    done_next   = 1'b1;
                    result_next = '0;
                end
                default:
                begin
                    state_next = ST_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chk_v_reg <= 1'b0;
            vld_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_v_reg <= chk_v_next;
            vld_reg   <= vld_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        typ_reg     <= typ_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        rd_vld_reg  <= rd_vld_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= CW'(SLOTS), "active count above pool size")
    `ASSERT_IMPLY(a_we_scan, clk, rst_n, mem_we, state_reg == ST_SCAN, "slot write outside scan")
    `ASSERT_IMPLY(a_kill_cnt, clk, rst_n, mem_we && (op_reg == CMD_KILL), cnt_reg != '0, "kill with empty count")
    `ASSERT_IMPLY(a_spawn_room, clk, rst_n, mem_we && (op_reg == CMD_SPAWN), cnt_reg != CW'(SLOTS), "spawn into full pool")
    `ASSERT_IMPLY(a_hit_op, clk, rst_n, done_reg && result_reg.hit, (op_reg == CMD_SPAWN) || (op_reg == CMD_FIND), "hit on kill or clear")

endmodule

/* sv/tspa_slot_ram.sv */
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tspa_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  tspa_pkg::slot_entry_t wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output tspa_pkg::slot_entry_t rdata
);
    import tspa_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
